/* hdl/xsg_pkg.sv */
package xsg_pkg;

    // Request codes
    localparam logic [1:0] REQ_NEXT = 2'd0;
    localparam logic [1:0] REQ_JUMP = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;

    // Scrambling multiplier (odd), applied modulo 2^64
    localparam logic [63:0] XS_MULT = 64'd1181783497276652981;

    // Last step of a jump: the step counter wraps after this one
    localparam logic [9:0] JUMP_LAST = 10'h3FF;

    localparam int unsigned NUM_WORDS = 16;

    // Jump polynomial, 1024 bits, least significant word first
    localparam logic [63:0] JUMP_POLY [NUM_WORDS] = '{
        64'h84242f96eca9c41d, 64'ha3c65b8776f96855,
        64'h5b34a39f070b5837, 64'h4489affce4f31a1e,
        64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
        64'h3659132bb12fea70, 64'haac17d8efa43cab8,
        64'hc4cb815590989b13, 64'h5ee975283d71c93b,
        64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
        64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d,
        64'hb99181f2d8f685ca, 64'h284600e3f30e38c3
    };

    // Control word from the sequencer to the state word store
    typedef struct packed {
        logic advance;    // one generator step
        logic rotate;     // plain rotation by one slot, position + 1
        logic load_wr;    // write one state word
        logic acc_clear;  // clear the jump accumulator
        logic acc_xor;    // fold all words into the accumulator
        logic acc_copy;   // copy the accumulator back to the state
    } wctl_t;

    // Bit of the jump polynomial for a given step
    function automatic logic jump_bit(input logic [9:0] step);
        logic [63:0] poly_word;
        begin
            poly_word = JUMP_POLY[step[9:6]];
            return poly_word[step[5:0]];
        end
    endfunction

endpackage

/* hdl/xorshift1024_star_generator_unit.sv */
// A next request steps the generator and scrambles the new word in the multiply,
// a load realigns the slots one place a cycle, a jump makes 1024 steps, one a
// cycle, then the copy back. The multiply is 3 passes of a 32 x 32. One request
// at a time, busy high until the strobe; code three strobes a zero word, never busy.
// Reset clears the state words, position and sequencer; result_valid is a
// single-cycle strobe that the receiver cannot stall.
module xorshift1024_star_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  word_index,
    input  logic [63:0] word_value,
    output logic        result_valid,
    output logic [63:0] random_value,
    output logic [51:0] unit_fraction
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_MUL,
        S_JUMP,
        S_JUMP_COPY,
        S_LOAD
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [9:0]     count_reg;
    logic [9:0]     count_next;
    logic           strobe_reg;
    logic           strobe_next;
    logic [63:0]    value_reg;
    logic [63:0]    value_next;

    xsg_pkg::wctl_t ctl;
    logic           mul_start;
    logic           mul_done;
    logic [63:0]    mul_product;
    logic [3:0]     position;
    logic [63:0]    mix_word;
    logic [3:0]     load_slot;

    // Slot that holds physical word word_index
    assign load_slot = 4'(word_index - position);

    xsg_words u_words (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .load_slot  (load_slot),
        .load_value (word_value),
        .position   (position),
        .mix_word   (mix_word)
    );

    xsg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mix_word),
        .done    (mul_done),
        .product (mul_product)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        value_next  = value_reg;
        ctl         = '0;
        mul_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        xsg_pkg::REQ_NEXT:
                        begin
                            state_next = S_NEXT;
                        end
                        xsg_pkg::REQ_JUMP:
                        begin
                            ctl.acc_clear = 1'b1;
                            count_next    = '0;
                            state_next    = S_JUMP;
                        end
                        xsg_pkg::REQ_LOAD:
                        begin
                            ctl.load_wr = 1'b1;
                            state_next  = S_LOAD;
                        end
                        default:
                        begin
                            // unused code: no state change, zero word
                            strobe_next = 1'b1;
                            value_next  = '0;
                        end
                    endcase
                end
            end
            S_NEXT:
            begin
                ctl.advance = 1'b1;
                mul_start   = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    strobe_next = 1'b1;
                    value_next  = mul_product;
                    state_next  = S_IDLE;
                end
            end
            S_JUMP:
            begin
                ctl.advance = 1'b1;
                ctl.acc_xor = xsg_pkg::jump_bit(count_reg);
                count_next  = count_reg + 10'd1;
                if (count_reg == xsg_pkg::JUMP_LAST)
                begin
                    state_next = S_JUMP_COPY;
                end
            end
            S_JUMP_COPY:
            begin
                ctl.acc_copy = 1'b1;
                strobe_next  = 1'b1;
                value_next   = '0;
                state_next   = S_IDLE;
            end
            S_LOAD:
            begin
                // realign so that the position is zero again
                if (position == 4'd0)
                begin
                    strobe_next = 1'b1;
                    value_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.rotate = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            value_reg  <= value_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = strobe_reg;
    assign random_value  = value_reg;
    assign unit_fraction = value_reg[63:12];

endmodule

/* hdl/xsg_mul.sv */
// Iterative 64 x 64 -> low 64 multiply by the scrambling constant,
// built from one shared 32 x 32 multiplier used over three passes.
module xsg_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [63:0] product
);

    logic        active_reg;
    logic [1:0]  step_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul_full;

    // Operand selection: lo*lo, hi*lo, lo*hi
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_a = x_reg[31:0];
                op_b = xsg_pkg::XS_MULT[31:0];
            end
            2'd1:
            begin
                op_a = x_reg[63:32];
                op_b = xsg_pkg::XS_MULT[31:0];
            end
            2'd2:
            begin
                op_a = x_reg[31:0];
                op_b = xsg_pkg::XS_MULT[63:32];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full = {32'd0, op_a} * {32'd0, op_b};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath: product registered, folded in on the following pass
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
        end
        else if (active_reg)
        begin
            prod_reg <= mul_full;
            case (step_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2,
                2'd3:    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hdl/xsg_words.sv */
// State word store kept in position order: slot 0 holds the word at the
// current position, slot k the word k places on. A step or rotation shifts
// the slots by one, so every read is at a fixed slot.
module xsg_words (
    input  logic          clk,
    input  logic          rst_n,
    input  xsg_pkg::wctl_t ctl,
    input  logic [3:0]    load_slot,
    input  logic [63:0]   load_value,
    output logic [3:0]    position,
    output logic [63:0]   mix_word
);

    logic [63:0] slot_reg [xsg_pkg::NUM_WORDS];
    logic [63:0] slot_next [xsg_pkg::NUM_WORDS];
    logic [63:0] acc_reg [xsg_pkg::NUM_WORDS];
    logic [63:0] acc_next [xsg_pkg::NUM_WORDS];
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;

    logic [63:0] b_sh;

    // xorshift mix of the current word and the next one
    assign b_sh     = slot_reg[1] ^ (slot_reg[1] << 31);
    assign mix_word = b_sh ^ slot_reg[0] ^ (b_sh >> 11) ^ (slot_reg[0] >> 30);

    // Slot update
    always_comb
    begin
        slot_next = slot_reg;
        pos_next  = pos_reg;
        if (ctl.acc_copy)
        begin
            slot_next = acc_reg;
        end
        else if (ctl.advance || ctl.rotate)
        begin
            for (int k = 0; k < xsg_pkg::NUM_WORDS - 1; k++)
            begin
                slot_next[k] = slot_reg[k + 1];
            end
            slot_next[xsg_pkg::NUM_WORDS - 1] = slot_reg[0];
            if (ctl.advance)
            begin
                slot_next[0] = mix_word;
            end
            pos_next = pos_reg + 4'd1;
        end
        else if (ctl.load_wr)
        begin
            slot_next[load_slot] = load_value;
        end
    end

    // Jump accumulator
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.acc_clear)
        begin
            for (int k = 0; k < xsg_pkg::NUM_WORDS; k++)
            begin
                acc_next[k] = '0;
            end
        end
        else if (ctl.acc_xor)
        begin
            for (int k = 0; k < xsg_pkg::NUM_WORDS; k++)
            begin
                acc_next[k] = acc_reg[k] ^ slot_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int k = 0; k < xsg_pkg::NUM_WORDS; k++)
            begin
                slot_reg[k] <= '0;
                acc_reg[k]  <= '0;
            end
        end
        else
        begin
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            acc_reg  <= acc_next;
        end
    end

    assign position = pos_reg;

endmodule

/* tb/xsg_stream_checker.sv */
`timescale 1ns / 1ps

// Watches the request and result channels of the xorshift1024* unit, keeps its
// own copy of the generator and matches every result word against it.
module xsg_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  word_index,
    input  logic [63:0] word_value,
    input  logic        result_valid,
    input  logic [63:0] random_value,
    input  logic [51:0] unit_fraction,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [63:0] number;
        logic [51:0] fraction;
    } draw_t;

    // words still owed by the unit, oldest first
    draw_t       due_draws [$];

    // shadow generator
    logic [63:0] gen_state [xsg_pkg::NUM_WORDS];
    logic [3:0]  slot;

    // one xorshift step; the new word lands at the next slot
    function automatic logic [63:0] advance_state();
        logic [63:0] prev;
        logic [63:0] cur;
        prev = gen_state[slot];
        slot = slot + 4'd1;
        cur  = gen_state[slot];
        cur  = cur ^ (cur << 31);
        gen_state[slot] = cur ^ prev ^ (cur >> 11) ^ (prev >> 30);
        return gen_state[slot];
    endfunction

    // jump ahead by 2^512: fold the words in at every set polynomial bit
    task automatic jump_state();
        logic [63:0] acc [xsg_pkg::NUM_WORDS];
        logic [63:0] discard;
        for (int j = 0; j < xsg_pkg::NUM_WORDS; j++)
            acc[j] = '0;
        for (int k = 0; k < 1024; k++)
        begin
            if (xsg_pkg::JUMP_POLY[k / 64][k % 64])
            begin
                for (int j = 0; j < xsg_pkg::NUM_WORDS; j++)
                    acc[j] = acc[j] ^ gen_state[4'(j) + slot];
            end
            discard = advance_state();
        end
        for (int j = 0; j < xsg_pkg::NUM_WORDS; j++)
            gen_state[4'(j) + slot] = acc[j];
    endtask

    // compare results first, then predict for a newly taken request
    always @(posedge clk or negedge rst_n)
    begin : watch
        draw_t want;
        draw_t got;
        int    errs;
        if (!rst_n)
        begin
            for (int i = 0; i < xsg_pkg::NUM_WORDS; i++)
                gen_state[i] = '0;
            slot = '0;
            due_draws.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (result_valid)
            begin
                if (due_draws.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h / %h",
                             $time, random_value, unit_fraction);
                    errs++;
                end
                else
                begin
                    want = due_draws.pop_front();
                    got  = '{number: random_value, fraction: unit_fraction};
                    if (got.number !== want.number)
                    begin
                        $display("%0t: random_value mismatch: expected %h, actual %h",
                                 $time, want.number, got.number);
                        errs++;
                    end
                    if (got.fraction !== want.fraction)
                    begin
                        $display("%0t: unit_fraction mismatch: expected %h, actual %h",
                                 $time, want.fraction, got.fraction);
                        errs++;
                    end
                end
            end

            if (start && !busy)
            begin
                want = '0;
                case (req_type)
                    xsg_pkg::REQ_NEXT:
                    begin
                        want.number   = advance_state() * xsg_pkg::XS_MULT;
                        want.fraction = want.number[63:12];
                    end
                    xsg_pkg::REQ_JUMP: jump_state();
                    xsg_pkg::REQ_LOAD:
                    begin
                        gen_state[word_index] = word_value;
                        slot = '0;
                    end
                    default: ;  // unused code: no effect, zero word
                endcase
                due_draws.push_back(want);
            end

            fail_count  <= fail_count + errs;
            outstanding <= due_draws.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    // unused request code, answered by the unit with a zero word
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int ITEMS     = 1650;
    localparam int CALM_TAIL = 200;
    localparam int MAX_JUMPS = 40;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  req_type    = xsg_pkg::REQ_NEXT;
    logic [3:0]  word_index  = '0;
    logic [63:0] word_value  = '0;
    logic        busy;
    logic        result_valid;
    logic [63:0] random_value;
    logic [51:0] unit_fraction;

    int fail_count;
    int outstanding;

    int  n_items;
    int  n_next;
    int  n_jump;
    int  n_load;
    int  n_spare;
    bit  gaps_on;
    bit  drained;

    xorshift1024_star_generator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .word_index    (word_index),
        .word_value    (word_value),
        .result_valid  (result_valid),
        .random_value  (random_value),
        .unit_fraction (unit_fraction)
    );

    xsg_stream_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .word_index    (word_index),
        .word_value    (word_value),
        .result_valid  (result_valid),
        .random_value  (random_value),
        .unit_fraction (unit_fraction),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // mostly random words, now and then all zeros or all ones
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // present one request and hold it until taken; maybe idle afterwards
    task automatic issue(input logic [1:0] kind, input logic [3:0] idx,
                         input logic [63:0] val);
        start      <= 1'b1;
        req_type   <= kind;
        word_index <= idx;
        word_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (kind)
            xsg_pkg::REQ_NEXT: n_next++;
            xsg_pkg::REQ_JUMP: n_jump++;
            xsg_pkg::REQ_LOAD: n_load++;
            default:           n_spare++;
        endcase
        if (kind != REQ_SPARE)
            n_items++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    // hold off until every owed word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [3:0] order [16];
        logic [3:0] tmp;
        int         pick;
        int         sw;
        int         waited;

        gaps_on = 1'b1;
        drained = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all-zero generator, unused code, full load with extremes
        issue(xsg_pkg::REQ_NEXT, 4'd0, '0);
        issue(REQ_SPARE, 4'hf, '1);
        for (int i = 0; i < 16; i++)
            issue(xsg_pkg::REQ_LOAD, 4'(i), (i == 0) ? '1 : (i == 7) ? 64'd0 :
                                            (i == 15) ? 64'd1 : rand_word());
        issue(xsg_pkg::REQ_NEXT, 4'hf, '1);
        issue(xsg_pkg::REQ_NEXT, 4'd0, '0);
        issue(xsg_pkg::REQ_JUMP, 4'd5, rand_word());
        issue(xsg_pkg::REQ_NEXT, 4'd3, rand_word());
        issue(REQ_SPARE, 4'd0, '0);

        // random: bursts of draws, reloads, jumps and stray requests
        while (n_items < ITEMS)
        begin
            gaps_on = (n_items < ITEMS - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                for (int i = 0; i < 16; i++)
                    order[i] = 4'(i);
                for (int i = 15; i > 0; i--)
                begin
                    sw = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[sw];
                    order[sw] = tmp;
                end
                for (int i = 0; i < 16; i++)
                    issue(xsg_pkg::REQ_LOAD, order[i], rand_word());
            end
            else if (pick < 12 && n_jump < MAX_JUMPS)
                issue(xsg_pkg::REQ_JUMP, 4'($urandom), rand_word());
            else if (pick < 16)
                issue(REQ_SPARE, 4'($urandom), rand_word());
            else if (pick < 21)
                issue(xsg_pkg::REQ_LOAD, 4'($urandom), rand_word());
            else
            begin
                repeat ($urandom_range(1, 24))
                    issue(xsg_pkg::REQ_NEXT, 4'($urandom), rand_word());
            end

            if (gaps_on && (!drained && n_items >= ITEMS / 2 ||
                            $urandom_range(0, 39) == 0))
            begin
                drain();
                drained = 1'b1;
            end
        end

        // wind down and let any stray strobe show up
        start <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40)
            @(posedge clk);

        if (outstanding != 0)
            $display("%0t: %0d words never arrived", $time, outstanding);
        $display("Covered %0d draws, %0d jumps, %0d word loads, %0d unused-code requests.",
                 n_next, n_jump, n_load, n_spare);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hdl/xsg_pkg.sv
hdl/xsg_mul.sv
hdl/xsg_words.sv
hdl/xorshift1024_star_generator_unit.sv
tb/xsg_stream_checker.sv
tb/tb_top.sv
